// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked check on i_clk, switched off while i_rst_n is low
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check on i_clk that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ASSERT_SYNC(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- sv/fccw_pkg.sv -----
// ----------------------------------------------------------------------------
// fccw_pkg
// types and constants of the fat12 cluster chain walker
// ----------------------------------------------------------------------------
`default_nettype none

package fccw_pkg;

    localparam int TBL_ADDR_W = 13;
    localparam int CLUSTER_W  = 12;
    localparam int LBA_W      = 32;
    localparam int SPC_W      = 8;
    localparam int PROD_W     = CLUSTER_W + SPC_W;
    localparam int CFG_IDX_W  = 1;

    // entries at or above this value mark the end of a chain
    localparam logic [CLUSTER_W-1:0] ENTRY_END = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_START   = 2'd1,
        OP_ADVANCE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ENDED = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_START = 1'b0,
        CFG_SPC        = 1'b1
    } t_cfg_idx;

    // table byte write request
    typedef struct packed {
        logic                  en;
        logic [TBL_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } t_tbl_wr;

    // table byte pair read request
    typedef struct packed {
        logic                  en;
        logic [TBL_ADDR_W-1:0] pos;
    } t_tbl_rd;

endpackage

`default_nettype wire

// ----- sv/fccw_in_if.sv -----
// ----------------------------------------------------------------------------
// fccw_in_if
// input channel: table writes, chain starts and advances
// ----------------------------------------------------------------------------
`default_nettype none

interface fccw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [12:0] table_address;
    logic [7:0]  table_byte;
    logic [11:0] start_cluster;

    modport source (
        output valid, opcode, table_address, table_byte, start_cluster,
        input  ready
    );
    modport sink (
        input  valid, opcode, table_address, table_byte, start_cluster,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/fccw_out_if.sv -----
// ----------------------------------------------------------------------------
// fccw_out_if
// output channel: one beat per start or advance, whether it ends, fails the range check or visits a cluster
// ----------------------------------------------------------------------------
`default_nettype none

interface fccw_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] cluster;
    logic [31:0] sector_lba;
    logic        is_last;
    logic [1:0]  status;

    modport source (
        output valid, cluster, sector_lba, is_last, status,
        input  ready
    );
    modport sink (
        input  valid, cluster, sector_lba, is_last, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/fat12_cluster_chain_walker_top.sv -----
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// fat12 allocation table store and cluster chain walker
// ----------------------------------------------------------------------------
// A table write beat is taken whenever ready is high; ready stays high
// after it. A start or advance beat passes through these steps: the accept
// cycle selects the cluster, checks its range, issues the read of its byte
// pair from the table banks and forms (cluster-2)*sectors_per_cluster; the
// walk stage then unpacks the entry, adds data_start_lba and loads the
// result register. The table read is registered and there is a single walk
// stage; the next beat is taken while a result still waits, and the walk
// stage holds only while the result register is full and not drained. No
// clearing pass runs after reset: bytes never written are simply not to be read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fat12_cluster_chain_walker_top #(
    parameter int TABLE_BYTES = 8192
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [fccw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fccw_pkg::LBA_W-1:0]       i_cfg_wdata,
    fccw_in_if.sink                               in_ch,
    fccw_out_if.source                            out_ch
);
    import fccw_pkg::*;

    localparam int LIM_W = TBL_ADDR_W + 1;
    localparam logic [LIM_W-1:0] LIMIT = LIM_W'(TABLE_BYTES);

    // configuration and chain state
    logic [LBA_W-1:0]     r_data_start;
    logic [SPC_W-1:0]     r_spc;
    logic [CLUSTER_W-1:0] r_pending;
    logic                 r_chain_active;

    // walk stage
    logic                 r_busy;
    logic [CLUSTER_W-1:0] r_s1_cl;
    logic                 r_s1_range;
    logic                 r_s1_ended;
    logic [PROD_W-1:0]    r_s1_prod;

    // result register
    logic                 r_out_valid;
    logic [CLUSTER_W-1:0] r_out_cl;
    logic [LBA_W-1:0]     r_out_lba;
    logic                 r_out_last;
    t_status              r_out_status;

    logic                 in_acc;
    t_opcode              op;
    logic                 is_walk;
    logic [CLUSTER_W-1:0] cl_sel;
    logic [CLUSTER_W-1:0] cl_m2;
    logic [TBL_ADDR_W:0]  cl_x3;
    logic [TBL_ADDR_W-1:0] pos;
    logic [LIM_W-1:0]     pos_p1;
    logic                 range_bad;
    logic                 ended;
    t_tbl_wr              tbl_wr;
    t_tbl_rd              tbl_rd;
    logic [15:0]          pair;
    logic                 s1_done;
    logic [CLUSTER_W-1:0] next_entry;
    logic                 s1_last;

    logic [CLUSTER_W-1:0] n_out_cl;
    logic [LBA_W-1:0]     n_out_lba;
    logic                 n_out_last;
    t_status              n_out_status;
    logic [CLUSTER_W-1:0] n_pending;
    logic                 n_chain_active;

    // input side decode, nothing taken while in reset
    assign in_ch.ready = i_rst_n && !r_busy;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign op          = t_opcode'(in_ch.opcode);

    always_comb begin
        is_walk = 1'b0;
        ended   = 1'b0;
        unique case (op)
            OP_WRITE:   is_walk = 1'b0;
            OP_START:   is_walk = 1'b1;
            OP_ADVANCE: begin
                is_walk = 1'b1;
                ended   = !r_chain_active;
            end
            default:    is_walk = 1'b0;
        endcase
    end

    // cluster selection, byte position and range check
    assign cl_sel    = (op == OP_START) ? in_ch.start_cluster : r_pending;
    assign cl_m2     = cl_sel - FIRST_DATA_CLUSTER;
    assign cl_x3     = {1'b0, cl_sel, 1'b0} + {2'b00, cl_sel};
    assign pos       = cl_x3[TBL_ADDR_W:1];
    assign pos_p1    = {1'b0, pos} + 1'b1;
    assign range_bad = (cl_sel < FIRST_DATA_CLUSTER) || (pos_p1 >= LIMIT);

    // table requests
    assign tbl_wr.en   = in_acc && (op == OP_WRITE);
    assign tbl_wr.addr = in_ch.table_address;
    assign tbl_wr.data = in_ch.table_byte;
    assign tbl_rd.en   = in_acc && is_walk && !ended && !range_bad;
    assign tbl_rd.pos  = pos;

    fccw_table #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_table (
        .i_clk  (i_clk),
        .i_wr   (tbl_wr),
        .i_rd   (tbl_rd),
        .o_pair (pair)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= '0;
            r_spc        <= SPC_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DATA_START: r_data_start <= i_cfg_wdata;
                CFG_SPC:        r_spc        <= i_cfg_wdata[SPC_W-1:0];
                default:        r_data_start <= r_data_start;
            endcase
        end
    end

    // walk stage load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc && is_walk) begin
            r_busy <= 1'b1;
        end else if (s1_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_walk) begin
            r_s1_cl    <= cl_sel;
            r_s1_range <= range_bad;
            r_s1_ended <= ended;
            r_s1_prod  <= {{SPC_W{1'b0}}, cl_m2} * {{CLUSTER_W{1'b0}}, r_spc};
        end
    end

    // walk stage completion: unpack entry and form the result
    assign s1_done    = r_busy && (!r_out_valid || out_ch.ready);
    assign next_entry = r_s1_cl[0] ? pair[15:4] : pair[11:0];
    assign s1_last    = next_entry >= ENTRY_END;

    always_comb begin
        n_pending      = r_pending;
        n_chain_active = r_chain_active;
        n_out_cl       = r_s1_cl;
        n_out_lba      = '0;
        n_out_last     = 1'b1;
        n_out_status   = ST_OK;
        if (r_s1_ended) begin
            n_out_cl     = '0;
            n_out_status = ST_ENDED;
        end else if (r_s1_range) begin
            n_pending      = '0;
            n_chain_active = 1'b0;
            n_out_status   = ST_RANGE;
        end else begin
            n_pending      = next_entry;
            n_chain_active = !s1_last;
            n_out_lba      = r_data_start + {{(LBA_W-PROD_W){1'b0}}, r_s1_prod};
            n_out_last     = s1_last;
        end
    end

    // chain state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= '0;
            r_chain_active <= 1'b0;
        end else if (s1_done) begin
            r_pending      <= n_pending;
            r_chain_active <= n_chain_active;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_out_cl     <= n_out_cl;
            r_out_lba    <= n_out_lba;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
        end
    end

    assign out_ch.valid      = r_out_valid;
    assign out_ch.cluster    = r_out_cl;
    assign out_ch.sector_lba = r_out_lba;
    assign out_ch.is_last    = r_out_last;
    assign out_ch.status     = r_out_status;

    // checks
    `ASSERT_SYNC(a_walk_enters_stage, in_ch.valid && in_ch.ready && (in_ch.opcode == OP_START || in_ch.opcode == OP_ADVANCE) |=> r_busy, "walk beat did not enter the walk stage")
    `ASSERT_SYNC(a_no_result_overwrite, s1_done |-> (!r_out_valid || out_ch.ready), "result register overwritten before it was taken")
    `ASSERT_SYNC(a_ended_result, s1_done && r_s1_ended |=> out_ch.valid && out_ch.is_last && (out_ch.status == ST_ENDED) && !r_chain_active, "advance after end gave a wrong result")
    `ASSERT_SYNC(a_last_stops_chain, s1_done && !r_s1_ended && !r_s1_range && s1_last |=> !r_chain_active, "chain still active after its last cluster")
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_busy && !r_out_valid && !r_chain_active, "walker not idle after reset")

endmodule

`default_nettype wire

// ----- sv/fccw_table.sv -----
// ----------------------------------------------------------------------------
// fccw_table
// allocation table in two byte banks (even and odd addresses) so that the
// byte pair of one entry is read in one access, with registered outputs
// ----------------------------------------------------------------------------
`default_nettype none

module fccw_table #(
    parameter int TABLE_BYTES = 8192
) (
    input  wire logic              i_clk,
    input  wire fccw_pkg::t_tbl_wr i_wr,
    input  wire fccw_pkg::t_tbl_rd i_rd,
    output logic [15:0]            o_pair
);
    import fccw_pkg::*;

    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int BW         = $clog2(BANK_DEPTH);
    localparam int LIM_W      = TBL_ADDR_W + 1;
    localparam logic [LIM_W-1:0] LIMIT = LIM_W'(TABLE_BYTES);

    logic [7:0] r_even_mem [BANK_DEPTH];
    logic [7:0] r_odd_mem  [BANK_DEPTH];
    logic [7:0] r_even_q;
    logic [7:0] r_odd_q;
    logic       r_pos_odd;

    logic                    wr_ok;
    logic [BW-1:0]           wr_idx;
    logic [TBL_ADDR_W-2:0]   half;
    logic [TBL_ADDR_W-2:0]   half_p1;
    logic [BW-1:0]           even_idx;
    logic [BW-1:0]           odd_idx;

    // write address decode, writes past the table are dropped
    assign wr_ok  = i_wr.en && ({1'b0, i_wr.addr} < LIMIT);
    assign wr_idx = i_wr.addr[BW:1];

    // an odd pair start takes its high byte from the next even entry
    assign half     = i_rd.pos[TBL_ADDR_W-1:1];
    assign half_p1  = half + 1'b1;
    assign even_idx = i_rd.pos[0] ? half_p1[BW-1:0] : half[BW-1:0];
    assign odd_idx  = half[BW-1:0];

    // even bank
    always_ff @(posedge i_clk) begin
        if (wr_ok && !i_wr.addr[0]) begin
            r_even_mem[wr_idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_even_q <= r_even_mem[even_idx];
        end
    end

    // odd bank
    always_ff @(posedge i_clk) begin
        if (wr_ok && i_wr.addr[0]) begin
            r_odd_mem[wr_idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_odd_q   <= r_odd_mem[odd_idx];
            r_pos_odd <= i_rd.pos[0];
        end
    end

    // little-endian pair
    assign o_pair = r_pos_odd ? {r_even_q, r_odd_q} : {r_odd_q, r_even_q};

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fat12 cluster chain walker
// ----------------------------------------------------------------------------
// Loads allocation table bytes and walks chains through them. Each cluster
// beat is checked against a local model of the table and the chain state.
// A short directed table runs first. Random phases follow under several
// register settings, with random gaps on both channels and one long stall
// of the result side. Bytes are always written before the walker reads them.
// ----------------------------------------------------------------------------

module testbench;
    import fccw_pkg::*;

    localparam int TABLE_BYTES     = 8192;
    localparam int PHASE_ITEMS     = 180;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int LIMIT_NS        = 5_000_000;

    // opcode that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [TBL_ADDR_W-1:0] table_address;
        logic [7:0]            table_byte;
        logic [CLUSTER_W-1:0]  start_cluster;
    } walk_req_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [LBA_W-1:0]     sector_lba;
        logic                 is_last;
        t_status              status;
    } cluster_beat_t;

    typedef struct packed {
        walk_req_t     req;
        logic          typed;
        cluster_beat_t want;
    } dir_row_t;

    localparam cluster_beat_t NO_BEAT = '0;

    // directed rows: typed results only where obvious, the rest predicted
    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // advance straight after reset, no chain yet
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b1, '{12'd0, 32'd0, 1'b1, ST_ENDED}},
        // clusters below the first data cluster
        '{'{OP_START, 13'd0, 8'd0, 12'd0}, 1'b1, '{12'd0, 32'd0, 1'b1, ST_RANGE}},
        '{'{OP_START, 13'd0, 8'd0, 12'd1}, 1'b1, '{12'd1, 32'd0, 1'b1, ST_RANGE}},
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b1, '{12'd0, 32'd0, 1'b1, ST_ENDED}},
        // ignored opcode with every payload bit set
        '{'{OP_UNUSED, 13'h1FFF, 8'hFF, 12'hFFF}, 1'b0, NO_BEAT},
        // address and byte extremes
        '{'{OP_WRITE, 13'd0, 8'h00, 12'hFFF}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'h1FFF, 8'hFF, 12'h000}, 1'b0, NO_BEAT},
        // chain 2 -> 3 -> 4 -> end, cluster 5 links to 1
        '{'{OP_WRITE, 13'd3, 8'h03, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'd4, 8'h40, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'd5, 8'h00, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'd6, 8'hFF, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'd7, 8'h1F, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'd8, 8'h00, 12'd0}, 1'b0, NO_BEAT},
        // highest cluster, entry at the lowest end mark
        '{'{OP_WRITE, 13'd6142, 8'h80, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_WRITE, 13'd6143, 8'hFF, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_START, 13'd0, 8'd0, 12'd2}, 1'b0, NO_BEAT},
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b0, NO_BEAT},
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b1, '{12'd0, 32'd0, 1'b1, ST_ENDED}},
        '{'{OP_START, 13'd0, 8'd0, 12'd4095}, 1'b0, NO_BEAT},
        // start during a chain abandons it
        '{'{OP_START, 13'd0, 8'd0, 12'd3}, 1'b0, NO_BEAT},
        '{'{OP_START, 13'd0, 8'd0, 12'd5}, 1'b0, NO_BEAT},
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b1, '{12'd1, 32'd0, 1'b1, ST_RANGE}},
        '{'{OP_ADVANCE, 13'd0, 8'd0, 12'd0}, 1'b1, '{12'd0, 32'd0, 1'b1, ST_ENDED}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LBA_W-1:0]     i_cfg_wdata;

    fccw_in_if  in_ch ();
    fccw_out_if out_ch ();

    fat12_cluster_chain_walker_top #(
        .TABLE_BYTES (TABLE_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // local copy of the table, the chain and the registers
    logic [7:0]           fat_bytes [TABLE_BYTES];
    bit                   fat_loaded [TABLE_BYTES];
    logic [CLUSTER_W-1:0] next_cluster = '0;
    bit                   chain_live = 1'b0;
    logic [LBA_W-1:0]     cfg_data_start = '0;
    logic [SPC_W-1:0]     cfg_spc = 8'd1;

    cluster_beat_t expected_beats [$];
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    bit  send_burst     = 1'b0;
    bit  recv_burst     = 1'b0;
    bit  pressure_done  = 1'b0;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, a few long ones, none in a burst
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one visit: sector of cluster c, then follow its table entry
    function automatic cluster_beat_t visit_cluster(input logic [CLUSTER_W-1:0] c);
        int                   pos;
        logic [15:0]          pair;
        logic [CLUSTER_W-1:0] link;
        cluster_beat_t        r;
        pos = (int'(c) * 3) / 2;
        if (c < FIRST_DATA_CLUSTER || pos + 1 >= TABLE_BYTES) begin
            chain_live   = 1'b0;
            next_cluster = '0;
            r = '{c, 32'd0, 1'b1, ST_RANGE};
            return r;
        end
        pair = {fat_bytes[pos + 1], fat_bytes[pos]};
        link = c[0] ? pair[15:4] : pair[11:0];
        r.cluster    = c;
        r.sector_lba = cfg_data_start + (32'(c) - 32'd2) * 32'(cfg_spc);
        r.is_last    = (link >= ENTRY_END);
        r.status     = ST_OK;
        next_cluster = link;
        chain_live   = !r.is_last;
        return r;
    endfunction

    // apply one accepted beat, return 1 when it yields a cluster beat
    function automatic bit predict_beat(input walk_req_t req, output cluster_beat_t r);
        r = NO_BEAT;
        case (req.op)
            OP_WRITE: begin
                if (int'(req.table_address) < TABLE_BYTES) begin
                    fat_bytes[req.table_address]  = req.table_byte;
                    fat_loaded[req.table_address] = 1'b1;
                end
                return 1'b0;
            end
            OP_START: begin
                r = visit_cluster(req.start_cluster);
                return 1'b1;
            end
            OP_ADVANCE: begin
                if (!chain_live)
                    r = '{12'd0, 32'd0, 1'b1, ST_ENDED};
                else
                    r = visit_cluster(next_cluster);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // offer one beat after a random gap and log its outcome on accept
    task automatic send_beat(input walk_req_t req, input bit typed,
                             input cluster_beat_t typed_beat);
        int            idle;
        cluster_beat_t beat;
        idle = pick_gap(send_burst);
        if ($urandom_range(0, 99) < 3)
            send_burst = !send_burst;
        @(negedge i_clk);
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= req.op;
        in_ch.table_address <= req.table_address;
        in_ch.table_byte    <= req.table_byte;
        in_ch.start_cluster <= req.start_cluster;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (predict_beat(req, beat))
            expected_beats.push_back(typed ? typed_beat : beat);
        if (req.op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic write_byte(input int addr, input logic [7:0] value);
        walk_req_t req;
        req = '{OP_WRITE, 13'(addr), value, 12'($urandom)};
        send_beat(req, 1'b0, NO_BEAT);
    endtask

    // make sure the byte pair of cluster c holds known data
    task automatic fill_pair(input logic [CLUSTER_W-1:0] c);
        int pos;
        pos = (int'(c) * 3) / 2;
        if (c < FIRST_DATA_CLUSTER || pos + 1 >= TABLE_BYTES)
            return;
        if (!fat_loaded[pos])
            write_byte(pos, 8'($urandom));
        if (!fat_loaded[pos + 1])
            write_byte(pos + 1, 8'($urandom));
    endtask

    // write a 12-bit entry, keeping the neighbour's nibble
    task automatic set_entry(input logic [CLUSTER_W-1:0] c,
                             input logic [CLUSTER_W-1:0] link);
        int         pos;
        logic [7:0] lo;
        logic [7:0] hi;
        pos = (int'(c) * 3) / 2;
        lo  = fat_loaded[pos] ? fat_bytes[pos] : 8'($urandom);
        hi  = fat_loaded[pos + 1] ? fat_bytes[pos + 1] : 8'($urandom);
        if (c[0]) begin
            lo[7:4] = link[3:0];
            hi      = link[11:4];
        end else begin
            lo      = link[7:0];
            hi[3:0] = link[11:8];
        end
        write_byte(pos, lo);
        write_byte(pos + 1, hi);
    endtask

    // start or advance, loading any bytes the walk is about to read
    task automatic issue_walk(input logic [1:0] op, input logic [CLUSTER_W-1:0] c);
        walk_req_t req;
        if (op == OP_START)
            fill_pair(c);
        else if (chain_live)
            fill_pair(next_cluster);
        req.op            = op;
        req.table_address = 13'($urandom);
        req.table_byte    = 8'($urandom);
        req.start_cluster = (op == OP_START) ? c : 12'($urandom);
        send_beat(req, 1'b0, NO_BEAT);
    endtask

    // stray write, ignored opcode, lone start or lone advance
    task automatic noise_item();
        int        r;
        walk_req_t req;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            write_byte($urandom_range(0, TABLE_BYTES - 1), 8'($urandom));
        end else if (r < 40) begin
            req = '{OP_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom)};
            send_beat(req, 1'b0, NO_BEAT);
        end else if (r < 65) begin
            issue_walk(OP_START, 12'($urandom));
        end else begin
            issue_walk(OP_ADVANCE, '0);
        end
    endtask

    // chain tail: mostly an end mark, sometimes a bad or open link
    function automatic logic [CLUSTER_W-1:0] pick_tail();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 12'($urandom_range(32'hFF8, 32'hFFF));
        if (r < 78)
            return ENTRY_END - 12'd1;
        if (r < 90)
            return 12'($urandom_range(0, 1));
        return 12'($urandom);
    endfunction

    // build a chain in the table, then walk it with the odd interruption
    task automatic run_chain();
        logic [CLUSTER_W-1:0] links [$];
        int                   len;
        int                   top;
        int                   extra;
        len = $urandom_range(1, 6);
        top = ($urandom_range(0, 3) == 0) ? 4095 : 40;
        for (int i = 0; i < len; i++)
            links.push_back(12'($urandom_range(2, top)));
        for (int i = 0; i < len; i++)
            set_entry(links[i], (i == len - 1) ? pick_tail() : links[i + 1]);
        issue_walk(OP_START, links[0]);
        extra = $urandom_range(0, 2);
        for (int i = 1; i < len + extra; i++) begin
            if ($urandom_range(0, 99) < 10)
                noise_item();
            issue_walk(OP_ADVANCE, '0);
        end
    endtask

    // stop offering, let every result and any trailing work finish
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [LBA_W-1:0] start_lba,
                              input logic [SPC_W-1:0] spc);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_DATA_START;
        i_cfg_wdata <= start_lba;
        @(negedge i_clk);
        i_cfg_index <= CFG_SPC;
        i_cfg_wdata <= 32'(spc);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_data_start = start_lba;
        cfg_spc        = spc;
    endtask

    task automatic report_mismatch(input string why, input cluster_beat_t want,
                                   input cluster_beat_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: expected cluster %0d lba %h last %0d status %0d, got %0d %h %0d %0d",
                     why, want.cluster, want.sector_lba, want.is_last, want.status,
                     got.cluster, got.sector_lba, got.is_last, got.status);
    endtask

    // stimulus: directed rows, then random phases under several settings
    initial begin : stimulus
        int phase_end;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_index         = CFG_DATA_START;
        i_cfg_wdata         = '0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_WRITE;
        in_ch.table_address = '0;
        in_ch.table_byte    = '0;
        in_ch.start_cluster = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under the reset register values
        for (int row = 0; row < DIR_ROWS; row++)
            send_beat(DIRECTED[row].req, DIRECTED[row].typed, DIRECTED[row].want);
        settle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_regs(32'hFFFF_FFFF, 8'd128);
                1: write_regs(32'h0000_0000, 8'd1);
                2: write_regs($urandom, 8'd0);
                3: write_regs($urandom, 8'd255);
                default: write_regs($urandom, 8'($urandom_range(1, 128)));
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 70)
                    run_chain();
                else
                    noise_item();
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stalls and one long hold-off
    initial begin : result_sink
        int hold;
        hold         = 0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!pressure_done && results_seen >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold          = PRESSURE_CYCLES;
            end
            if ($urandom_range(0, 99) < 1)
                recv_burst = !recv_burst;
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!recv_burst && $urandom_range(0, 99) < 20)
                    hold = pick_gap(1'b0);
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        cluster_beat_t got;
        cluster_beat_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            got.cluster    = out_ch.cluster;
            got.sector_lba = out_ch.sector_lba;
            got.is_last    = out_ch.is_last;
            got.status     = t_status'(out_ch.status);
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", NO_BEAT, got);
            end else begin
                want = expected_beats.pop_front();
                if (got.cluster !== want.cluster || got.sector_lba !== want.sector_lba ||
                    got.is_last !== want.is_last || got.status !== want.status)
                    report_mismatch("beat mismatch", want, got);
            end
        end
    end

endmodule
